@@ src/ebmm_pkg.sv @@
package ebmm_pkg;

    localparam int UNIT_W      = 4;
    localparam int MOVE_W      = 8;
    localparam int TIME_W      = 32;
    localparam int VALUE_W     = 7;
    localparam int CHAN_W      = 5;
    localparam int SENS_W      = 4;
    localparam int STEP_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int Q_DEPTH     = 2;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_BTN = 1'b1;

    localparam logic MSG_NOTE = 1'b0;
    localparam logic MSG_CC   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd3;

    localparam logic [UNIT_W-1:0] ENC_ADJ_REL   = 4'd4;
    localparam logic [UNIT_W-1:0] ENC_ADJ_ABS   = 4'd5;
    localparam logic [UNIT_W-1:0] ENC_BRIGHT_LO = 4'd10;
    localparam logic [UNIT_W-1:0] ENC_BRIGHT_MI = 4'd11;
    localparam logic [UNIT_W-1:0] ENC_BRIGHT_HI = 4'd12;

    localparam logic [VALUE_W-1:0] REL_LEFT   = 7'd64;
    localparam logic [VALUE_W-1:0] MAX_VALUE  = 7'd127;
    localparam logic [SENS_W-1:0]  SENS_MIN   = 4'd1;
    localparam logic [SENS_W-1:0]  SENS_MAX   = 4'd8;
    localparam logic [SENS_W-1:0]  SENS_RESET = 4'd5;
    localparam int                 LEVEL_DIV  = 15;
    localparam int                 MAX_LEVEL  = 7;

    localparam logic [STEP_W-1:0] SPEED_TABLE [8][8] = '{
        '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1,  5'd1,  5'd2,  5'd2},
        '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1,  5'd2,  5'd2,  5'd3},
        '{5'd1, 5'd1, 5'd1, 5'd1, 5'd2,  5'd2,  5'd3,  5'd3},
        '{5'd1, 5'd1, 5'd1, 5'd2, 5'd2,  5'd3,  5'd4,  5'd4},
        '{5'd1, 5'd1, 5'd2, 5'd2, 5'd3,  5'd4,  5'd5,  5'd6},
        '{5'd1, 5'd2, 5'd3, 5'd4, 5'd5,  5'd6,  5'd7,  5'd8},
        '{5'd2, 5'd3, 5'd4, 5'd5, 5'd6,  5'd8,  5'd10, 5'd12},
        '{5'd3, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd15, 5'd18}
    };

    typedef struct packed {
        logic                     mode;
        logic [UNIT_W-1:0]        unit;
        logic signed [MOVE_W-1:0] movement;
        logic                     pin_level;
        logic [TIME_W-1:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic                message_kind;
        logic [CHAN_W-1:0]   number;
        logic [VALUE_W-1:0]  value;
        logic [CHAN_W-1:0]   channel;
        logic                latch_on;
        logic [SENS_W-1:0]   relative_level;
        logic [SENS_W-1:0]   absolute_level;
    } t_out_item;

    typedef struct packed {
        logic [CHAN_W-1:0] midi_channel;
        logic [15:0]       debounce_ms;
        logic [15:0]       long_press_ms;
        logic [7:0]        min_interval_ms;
    } t_cfg;

    // classified command handed from front to back
    typedef struct packed {
        logic                     is_btn;
        logic [UNIT_W-1:0]        unit;
        logic signed [MOVE_W-1:0] movement;
        logic                     pin_level;
        logic [TIME_W-1:0]        now_ms;
        logic                     is_rel;
        logic                     adj_rel;
        logic                     adj_abs;
        logic                     adj_group;
        logic                     is_latch;
    } t_cmd;

    // min(e / 15, 7)
    function automatic logic [2:0] speed_level(input logic [TIME_W-1:0] e);
        logic [2:0] lvl;
        lvl = 3'd0;
        if (e >= TIME_W'(LEVEL_DIV * MAX_LEVEL)) begin
            lvl = 3'(MAX_LEVEL);
        end else begin
            for (int k = 1; k < MAX_LEVEL; k++) begin
                if (e[6:0] >= 7'(LEVEL_DIV * k)) begin
                    lvl = 3'(k);
                end
            end
        end
        return lvl;
    endfunction

endpackage

@@ src/encoder_button_midi_mapper.sv @@
// Maps encoder movement reports and button pin samples to MIDI note and control change
// results. Items are accepted at one per clock while the queue is not full: the front end
// classifies each item and drops units out of range, a two-entry queue decouples it from
// the back end, and the back end updates all per-unit state and forms the result, so it
// sustains one item per cycle unless the output stalls. Items pass through the queue and
// the back end registers each result for the output. Configuration writes are taken every cycle.
module encoder_button_midi_mapper #(
    parameter int NUM_ENCODERS = 13,
    parameter int NUM_BUTTONS  = 14,
    parameter int NUM_RELATIVE = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ebmm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ebmm_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ebmm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ebmm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    ebmm_pkg::t_cfg r_cfg;
    ebmm_pkg::t_cmd front_cmd;
    ebmm_pkg::t_cmd q_cmd;
    logic           front_keep;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.midi_channel    <= 5'd1;
            r_cfg.debounce_ms     <= 16'd50;
            r_cfg.long_press_ms   <= 16'd500;
            r_cfg.min_interval_ms <= 8'd5;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ebmm_pkg::CFG_CHANNEL: begin
                    r_cfg.midi_channel <= i_cfg_data[ebmm_pkg::CHAN_W-1:0];
                end
                ebmm_pkg::CFG_DEBOUNCE: begin
                    r_cfg.debounce_ms <= i_cfg_data;
                end
                ebmm_pkg::CFG_LONG: begin
                    r_cfg.long_press_ms <= i_cfg_data;
                end
                ebmm_pkg::CFG_INTERVAL: begin
                    r_cfg.min_interval_ms <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    ebmm_front #(
        .NUM_ENCODERS (NUM_ENCODERS),
        .NUM_BUTTONS  (NUM_BUTTONS),
        .NUM_RELATIVE (NUM_RELATIVE)
    ) u_front (
        .i_item (i_in_data),
        .o_keep (front_keep),
        .o_cmd  (front_cmd)
    );

    ebmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !q_full && front_keep),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    ebmm_back #(
        .NUM_ENCODERS (NUM_ENCODERS),
        .NUM_BUTTONS  (NUM_BUTTONS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ src/ebmm_front.sv @@
module ebmm_front #(
    parameter int NUM_ENCODERS = 13,
    parameter int NUM_BUTTONS  = 14,
    parameter int NUM_RELATIVE = 5
) (
    input  ebmm_pkg::t_in_item i_item,
    output logic               o_keep,
    output ebmm_pkg::t_cmd     o_cmd
);

    logic [ebmm_pkg::UNIT_W-1:0] unit;

    assign unit = i_item.unit;

    always_comb begin
        o_cmd.is_btn    = (i_item.mode == ebmm_pkg::MODE_BTN);
        o_cmd.unit      = unit;
        o_cmd.movement  = i_item.movement;
        o_cmd.pin_level = i_item.pin_level;
        o_cmd.now_ms    = i_item.now_ms;
        o_cmd.is_rel    = ({1'b0, unit} < 5'(NUM_RELATIVE));
        o_cmd.adj_rel   = (unit == ebmm_pkg::ENC_ADJ_REL);
        o_cmd.adj_abs   = (unit == ebmm_pkg::ENC_ADJ_ABS);
        o_cmd.adj_group = (unit == ebmm_pkg::ENC_ADJ_REL)   || (unit == ebmm_pkg::ENC_ADJ_ABS)
                       || (unit == ebmm_pkg::ENC_BRIGHT_LO) || (unit == ebmm_pkg::ENC_BRIGHT_MI)
                       || (unit == ebmm_pkg::ENC_BRIGHT_HI);
        // only a button sample can be the latch button
        o_cmd.is_latch  = (i_item.mode == ebmm_pkg::MODE_BTN)
                       && ({1'b0, unit} == 5'(NUM_BUTTONS - 1));
        // out-of-range units are dropped here and never reach the queue
        if (o_cmd.is_btn) begin
            o_keep = ({1'b0, unit} < 5'(NUM_BUTTONS));
        end else begin
            o_keep = ({1'b0, unit} < 5'(NUM_ENCODERS));
        end
    end

endmodule

@@ src/ebmm_queue.sv @@
module ebmm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ebmm_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ebmm_pkg::t_cmd o_data
);

    localparam int PW = (ebmm_pkg::Q_DEPTH > 1) ? $clog2(ebmm_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(ebmm_pkg::Q_DEPTH + 1);

    ebmm_pkg::t_cmd  r_mem [ebmm_pkg::Q_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wp;
    logic [PW-1:0]   n_rp;

    assign o_full  = (r_cnt == CW'(ebmm_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp = (r_wp == PW'(ebmm_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp = (r_rp == PW'(ebmm_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ src/ebmm_back.sv @@
module ebmm_back #(
    parameter int NUM_ENCODERS = 13,
    parameter int NUM_BUTTONS  = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ebmm_pkg::t_cfg      i_cfg,
    input  logic                i_cmd_valid,
    input  ebmm_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ebmm_pkg::t_out_item o_out_data
);

    localparam int EIW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
    localparam int BIW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic [2:0]                         r_res      [NUM_ENCODERS];
    logic [ebmm_pkg::TIME_W-1:0]        r_move_t   [NUM_ENCODERS];
    logic [ebmm_pkg::VALUE_W-1:0]       r_abs      [NUM_ENCODERS];
    logic                               r_prev     [NUM_BUTTONS];
    logic [ebmm_pkg::TIME_W-1:0]        r_chg_t    [NUM_BUTTONS];
    logic                               r_adjust;
    logic [ebmm_pkg::TIME_W-1:0]        r_hold;
    logic                               r_latch;
    logic [ebmm_pkg::SENS_W-1:0]        r_rel_sens;
    logic [ebmm_pkg::SENS_W-1:0]        r_abs_sens;
    logic                               r_ov;
    ebmm_pkg::t_out_item                r_out;

    logic                               go;
    logic [EIW-1:0]                     ei;
    logic [BIW-1:0]                     bi;
    logic signed [8:0]                  sum;
    logic                               neg;
    logic [8:0]                         mag;
    logic                               detent;
    logic [2:0]                         n_res;
    logic [ebmm_pkg::TIME_W-1:0]        enc_el;
    logic                               enc_fire;
    logic                               enc_adjust;
    logic [2:0]                         level;
    logic [ebmm_pkg::SENS_W-1:0]        sens;
    logic [ebmm_pkg::STEP_W-1:0]        step;
    logic signed [9:0]                  abs_sum;
    logic [ebmm_pkg::VALUE_W-1:0]       n_abs;
    logic [ebmm_pkg::VALUE_W-1:0]       enc_value;
    logic [ebmm_pkg::SENS_W-1:0]        n_rel_sens;
    logic [ebmm_pkg::SENS_W-1:0]        n_abs_sens;
    logic [ebmm_pkg::TIME_W-1:0]        btn_el;
    logic                               btn_fire;
    logic                               latch_press;
    logic                               latch_release;
    logic                               latch_quick;
    logic                               n_latch;
    logic                               emit;
    ebmm_pkg::t_out_item                n_out;

    assign go          = i_cmd_valid && (!r_ov || i_out_ready);
    assign o_cmd_pop   = go;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        ei = i_cmd.unit[EIW-1:0];
        bi = i_cmd.unit[BIW-1:0];

        // encoder path
        sum    = {{6{r_res[ei][2]}}, r_res[ei]} + {i_cmd.movement[7], i_cmd.movement};
        neg    = sum[8];
        mag    = neg ? (9'd0 - sum) : sum;
        detent = (sum >= 9'sd4) || (sum <= -9'sd4);
        if (!detent) begin
            n_res = sum[2:0];
        end else begin
            // remainder truncated toward zero keeps the sign of the sum
            n_res = neg ? (3'd0 - {1'b0, mag[1:0]}) : {1'b0, mag[1:0]};
        end
        enc_el     = i_cmd.now_ms - r_move_t[ei];
        enc_fire   = detent && (enc_el >= {24'd0, i_cfg.min_interval_ms});
        enc_adjust = r_adjust && i_cmd.adj_group;
        level      = ebmm_pkg::speed_level(enc_el);
        sens       = i_cmd.is_rel ? r_rel_sens : r_abs_sens;
        step       = ebmm_pkg::SPEED_TABLE[3'(sens - 1'b1)][3'(3'(ebmm_pkg::MAX_LEVEL) - level)];

        abs_sum = {3'd0, r_abs[ei]} + (neg ? (10'sd0 - {5'd0, step}) : {5'd0, step});
        if (abs_sum < 0) begin
            n_abs = '0;
        end else if (abs_sum > 10'sd127) begin
            n_abs = ebmm_pkg::MAX_VALUE;
        end else begin
            n_abs = abs_sum[6:0];
        end
        if (i_cmd.is_rel) begin
            enc_value = neg ? (ebmm_pkg::REL_LEFT + {2'd0, step}) : {2'd0, step};
        end else begin
            enc_value = n_abs;
        end

        n_rel_sens = r_rel_sens;
        n_abs_sens = r_abs_sens;
        if (i_cmd.adj_rel) begin
            if (!neg && r_rel_sens < ebmm_pkg::SENS_MAX) n_rel_sens = r_rel_sens + 1'b1;
            if (neg && r_rel_sens > ebmm_pkg::SENS_MIN)  n_rel_sens = r_rel_sens - 1'b1;
        end
        if (i_cmd.adj_abs) begin
            if (!neg && r_abs_sens < ebmm_pkg::SENS_MAX) n_abs_sens = r_abs_sens + 1'b1;
            if (neg && r_abs_sens > ebmm_pkg::SENS_MIN)  n_abs_sens = r_abs_sens - 1'b1;
        end

        // button path
        btn_el        = i_cmd.now_ms - r_chg_t[bi];
        btn_fire      = (btn_el > {16'd0, i_cfg.debounce_ms}) && (i_cmd.pin_level != r_prev[bi]);
        latch_press   = i_cmd.is_latch && !i_cmd.pin_level && !r_adjust;
        latch_release = i_cmd.is_latch && i_cmd.pin_level && r_adjust;
        latch_quick   = (i_cmd.now_ms - r_hold) < {16'd0, i_cfg.long_press_ms};
        n_latch       = latch_release && latch_quick ? !r_latch : r_latch;

        n_out.number         = {1'b0, i_cmd.unit} + 5'd1;
        n_out.channel        = i_cfg.midi_channel;
        n_out.relative_level = r_rel_sens;
        n_out.absolute_level = r_abs_sens;
        n_out.latch_on       = n_latch;
        if (i_cmd.is_btn) begin
            n_out.message_kind = ebmm_pkg::MSG_NOTE;
            if (i_cmd.is_latch) begin
                n_out.value = n_latch ? ebmm_pkg::MAX_VALUE : '0;
                emit        = btn_fire && latch_release && latch_quick;
            end else begin
                n_out.value = i_cmd.pin_level ? 7'd0 : 7'd1;
                emit        = btn_fire;
            end
        end else begin
            n_out.message_kind = ebmm_pkg::MSG_CC;
            n_out.value        = enc_value;
            emit               = enc_fire && !enc_adjust;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENCODERS; i++) begin
                r_res[i]    <= '0;
                r_move_t[i] <= '0;
                r_abs[i]    <= '0;
            end
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_prev[i]  <= 1'b0;
                r_chg_t[i] <= '0;
            end
            r_adjust   <= 1'b0;
            r_hold     <= '0;
            r_latch    <= 1'b0;
            r_rel_sens <= ebmm_pkg::SENS_RESET;
            r_abs_sens <= ebmm_pkg::SENS_RESET;
            r_ov       <= 1'b0;
        end else begin
            if (go && emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (go && !i_cmd.is_btn) begin
                r_res[ei] <= n_res;
                if (enc_fire) begin
                    r_move_t[ei] <= i_cmd.now_ms;
                    if (enc_adjust) begin
                        r_rel_sens <= n_rel_sens;
                        r_abs_sens <= n_abs_sens;
                    end else if (!i_cmd.is_rel) begin
                        r_abs[ei] <= n_abs;
                    end
                end
            end
            if (go && i_cmd.is_btn && btn_fire) begin
                r_chg_t[bi] <= i_cmd.now_ms;
                r_prev[bi]  <= i_cmd.pin_level;
                if (latch_press) begin
                    r_hold   <= i_cmd.now_ms;
                    r_adjust <= 1'b1;
                end
                if (latch_release) begin
                    r_adjust <= 1'b0;
                    r_latch  <= n_latch;
                end
            end
        end
    end

    a_rel_sens_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rel_sens >= ebmm_pkg::SENS_MIN) && (r_rel_sens <= ebmm_pkg::SENS_MAX))
        else $error("relative sensitivity out of range");

    a_abs_sens_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_abs_sens >= ebmm_pkg::SENS_MIN) && (r_abs_sens <= ebmm_pkg::SENS_MAX))
        else $error("absolute sensitivity out of range");

    a_out_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(go))
        else $error("result appeared without a command");

    a_sens_only_in_adjust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_rel_sens) |-> $past(r_adjust))
        else $error("sensitivity changed outside adjust mode");

endmodule
